@@ design/whp_pkg.sv @@
package whp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE, PH_PRE, PH_CHDR, PH_FMT, PH_EXT, PH_SKIP, PH_DIV, PH_OUT
  } phase_e;

  localparam logic [31:0] TagRiff = 32'h46464952;
  localparam logic [31:0] TagWave = 32'h45564157;
  localparam logic [31:0] TagFmt  = 32'h20746D66;
  localparam logic [31:0] TagData = 32'h61746164;

  localparam logic [15:0] FmtPcm   = 16'd1;
  localparam logic [15:0] FmtFloat = 16'd3;
  localparam logic [15:0] FmtExt   = 16'hFFFE;
  localparam logic [31:0] FmtBaseLen = 32'd16;
  localparam logic [31:0] FmtExtLen  = 32'd40;

  localparam logic [3:0] ErrNone  = 4'd0;
  localparam logic [3:0] ErrRiff  = 4'd1;
  localparam logic [3:0] ErrWave  = 4'd2;
  localparam logic [3:0] ErrZero  = 4'd3;
  localparam logic [3:0] ErrInt   = 4'd4;
  localparam logic [3:0] ErrFloat = 4'd5;
  localparam logic [3:0] ErrUnk   = 4'd6;
  localparam logic [3:0] ErrShort = 4'd7;
  localparam logic [3:0] ErrNoFmt = 4'd8;
  localparam logic [3:0] ErrTrunc = 4'd9;

  // GUID byte tables, index 0..15 over bytes 8..23 of the extension
  function automatic logic [7:0] guid_byte(input logic [1:0] k, input logic [3:0] g);
    logic [63:0] head;
    logic [63:0] tail;
    begin
      tail = 64'h719b3800aa000080;
      unique case (k)
        2'd0:    head = 64'h0010000000000001;
        2'd1:    head = 64'h0010000000000003;
        default: head = 64'h1000000003000000;
      endcase
      if (g[3]) guid_byte = tail[g[2:0]*8 +: 8];
      else guid_byte = head[g[2:0]*8 +: 8];
    end
  endfunction

  // controller -> datapath commands
  typedef struct packed {
    logic       clear;      // first byte: reset datapath fields
    logic       step;       // byte consumed in an active phase
    phase_e     phase;
    logic [5:0] idx;
    logic       div_start;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic [31:0] tag_next;
    logic [31:0] len_next;
    logic [15:0] ftag_next;
    logic        skip_last;
    logic        ba_zero;
    logic [3:0]  fmt_err;   // finish_fmt result
    logic        fmt_skip_zero;
    logic        div_done;
  } stat_t;

endpackage

@@ design/whp_ctrl.sv @@
module whp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             first_byte_i,
  input  logic             final_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [3:0]       err_o,
  output logic             ok_o,
  output whp_pkg::cmd_t    cmd_o,
  input  whp_pkg::stat_t   stat_i
);

  whp_pkg::phase_e ph_q, ph_d;
  logic [5:0] idx_q, idx_d;
  logic [3:0] err_q, err_d;
  logic       ok_q, ok_d;
  logic       acc;
  whp_pkg::phase_e cur;
  logic [3:0] e;
  logic       res, done;

  assign in_ready_o  = (ph_q != whp_pkg::PH_DIV) && (ph_q != whp_pkg::PH_OUT);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = (ph_q == whp_pkg::PH_OUT);
  assign err_o       = err_q;
  assign ok_o        = ok_q;
  assign cur         = first_byte_i ? whp_pkg::PH_PRE : ph_q;

  // next state
  always_comb begin
    ph_d = ph_q; idx_d = idx_q; err_d = err_q; ok_d = ok_q;
    e = whp_pkg::ErrNone; res = 1'b0; done = 1'b0;
    cmd_o.clear = acc && first_byte_i;
    cmd_o.step  = 1'b0;
    cmd_o.phase = cur;
    cmd_o.idx   = first_byte_i ? 6'd0 : idx_q;
    cmd_o.div_start = 1'b0;
    if (ph_q == whp_pkg::PH_DIV) begin
      if (stat_i.div_done) ph_d = whp_pkg::PH_OUT;
    end else if (ph_q == whp_pkg::PH_OUT) begin
      if (out_ready_i) ph_d = whp_pkg::PH_IDLE;
    end else if (acc && cur != whp_pkg::PH_IDLE) begin
      cmd_o.step = 1'b1;
      ph_d = cur; idx_d = cmd_o.idx;
      unique case (cur)
        whp_pkg::PH_PRE: begin
          if (cmd_o.idx == 6'd3 && stat_i.tag_next != whp_pkg::TagRiff) e = whp_pkg::ErrRiff;
          else if (cmd_o.idx == 6'd11) begin
            if (stat_i.tag_next != whp_pkg::TagWave) e = whp_pkg::ErrWave;
            else begin ph_d = whp_pkg::PH_CHDR; idx_d = 6'd0; end
          end else idx_d = cmd_o.idx + 6'd1;
        end
        whp_pkg::PH_CHDR: begin
          if (idx_q >= 6'd7) begin
            if (stat_i.len_next == 32'd0) e = whp_pkg::ErrZero;
            else if (stat_i.tag_next == whp_pkg::TagFmt) begin
              if (stat_i.len_next < whp_pkg::FmtBaseLen) e = whp_pkg::ErrShort;
              else begin ph_d = whp_pkg::PH_FMT; idx_d = 6'd0; end
            end else if (stat_i.tag_next == whp_pkg::TagData) begin
              if (stat_i.ba_zero) e = whp_pkg::ErrNoFmt;
              else done = 1'b1;
            end else ph_d = whp_pkg::PH_SKIP;
          end else idx_d = idx_q + 6'd1;
        end
        whp_pkg::PH_FMT: begin
          if (idx_q >= 6'd15) begin
            if (stat_i.ftag_next == whp_pkg::FmtExt) begin
              if (stat_i.len_next < whp_pkg::FmtExtLen) e = whp_pkg::ErrShort;
              else begin ph_d = whp_pkg::PH_EXT; idx_d = 6'd0; end
            end else begin
              e = stat_i.fmt_err;
              ph_d = stat_i.fmt_skip_zero ? whp_pkg::PH_CHDR : whp_pkg::PH_SKIP;
              idx_d = 6'd0;
            end
          end else idx_d = idx_q + 6'd1;
        end
        whp_pkg::PH_EXT: begin
          if (idx_q >= 6'd23) begin
            e = stat_i.fmt_err;
            ph_d = stat_i.fmt_skip_zero ? whp_pkg::PH_CHDR : whp_pkg::PH_SKIP;
            idx_d = 6'd0;
          end else idx_d = idx_q + 6'd1;
        end
        whp_pkg::PH_SKIP: begin
          if (stat_i.skip_last) begin ph_d = whp_pkg::PH_CHDR; idx_d = 6'd0; end
        end
        default: ph_d = whp_pkg::PH_IDLE;
      endcase
      res = (e != whp_pkg::ErrNone) || done || final_byte_i;
      if (res) begin
        err_d = (e != whp_pkg::ErrNone) ? e : (done ? whp_pkg::ErrNone : whp_pkg::ErrTrunc);
        ok_d  = (e == whp_pkg::ErrNone) && done;
        ph_d  = ok_d ? whp_pkg::PH_DIV : whp_pkg::PH_OUT;
        cmd_o.div_start = ok_d;
      end
    end else if (acc) begin
      ph_d = whp_pkg::PH_IDLE;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= whp_pkg::PH_IDLE; idx_q <= '0; err_q <= '0; ok_q <= 1'b0;
    end else begin
      ph_q <= ph_d; idx_q <= idx_d; err_q <= err_d; ok_q <= ok_d;
    end
  end

endmodule

@@ design/whp_div.sv @@
module whp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [19:0] den_i,
  output logic [31:0] quot_o,
  output logic        done_o
);

  logic [31:0] q_q, q_d;
  logic [20:0] r_q, r_d;
  logic [19:0] den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [20:0] sh;

  assign quot_o = q_q;
  assign done_o = busy_q && (cnt_q == 6'd32);

  // restoring division, one quotient bit a cycle
  always_comb begin
    q_d = q_q; r_d = r_q; cnt_d = cnt_q; busy_d = busy_q;
    sh = {r_q[19:0], q_q[31]};
    if (start_i) begin
      q_d = num_i; r_d = '0; cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (cnt_q == 6'd32) busy_d = 1'b0;
      else begin
        cnt_d = cnt_q + 6'd1;
        if (sh >= {1'b0, den_q}) begin
          r_d = sh - {1'b0, den_q}; q_d = {q_q[30:0], 1'b1};
        end else begin
          r_d = sh; q_d = {q_q[30:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; r_q <= r_d;
    if (start_i) den_q <= den_i;
  end

endmodule

@@ design/whp_dp.sv @@
module whp_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     data_byte_i,
  input  whp_pkg::cmd_t  cmd_i,
  output whp_pkg::stat_t stat_o,
  output logic [2:0]     fmt_o,
  output logic [15:0]    chan_o,
  output logic [31:0]    rate_o,
  output logic [31:0]    pos_o,
  output logic [31:0]    frames_o
);

  logic [31:0] tag_q, tag_d, len_q, len_d, rate_q, rate_d, pos_q, pos_d;
  logic [15:0] ftag_q, ftag_d, ch_q, ch_d, bps_q, bps_d;
  logic [32:0] skip_q, skip_d;
  logic [2:0]  gm_q, gm_d, fh_q, fh_d;
  logic [19:0] ba_q, ba_d;
  logic [31:0] tag_b, len_b, rate_b;
  logic [15:0] ftag_b, ch_b, bps_b;
  logic [19:0] ba_b;
  logic [32:0] skip_b, pad;
  logic [2:0]  gm_b, gm_n, fc;
  logic [15:0] ft_eff, bps_n;
  logic [3:0]  ferr;
  logic [31:0] consumed;
  logic [5:0]  i;
  logic [3:0]  g;
  logic [1:0]  kk;
  logic        fin;
  logic        div_done;

  assign i = cmd_i.idx;

  // values after a first-byte clear
  always_comb begin
    tag_b = cmd_i.clear ? '0 : tag_q;   len_b = cmd_i.clear ? '0 : len_q;
    rate_b = cmd_i.clear ? '0 : rate_q; ftag_b = cmd_i.clear ? '0 : ftag_q;
    ch_b = cmd_i.clear ? '0 : ch_q;     bps_b = cmd_i.clear ? '0 : bps_q;
    ba_b = cmd_i.clear ? '0 : ba_q;     skip_b = cmd_i.clear ? '0 : skip_q;
    gm_b = cmd_i.clear ? 3'b111 : gm_q;
  end

  // field capture and format decision
  always_comb begin
    tag_d = tag_b; len_d = len_b; rate_d = rate_b; ftag_d = ftag_b; ch_d = ch_b;
    bps_d = bps_b; ba_d = ba_b; skip_d = skip_b; gm_d = gm_b; fh_d = fh_q;
    pos_d = cmd_i.clear ? 32'd0 : pos_q;
    gm_n = gm_b; fin = 1'b0; consumed = whp_pkg::FmtBaseLen;
    g = 4'(i - 6'd8); kk = 2'd0;
    bps_n = bps_b; ft_eff = ftag_b;
    case (cmd_i.phase)
      whp_pkg::PH_PRE: tag_d = {data_byte_i, tag_b[31:8]};
      whp_pkg::PH_CHDR: begin
        if (i < 6'd4) tag_d = {data_byte_i, tag_b[31:8]};
        else len_d = {data_byte_i, len_b[31:8]};
      end
      whp_pkg::PH_FMT: begin
        if (i < 6'd2) ftag_d = {data_byte_i, ftag_b[15:8]};
        else if (i < 6'd4) ch_d = {data_byte_i, ch_b[15:8]};
        else if (i < 6'd8) rate_d = {data_byte_i, rate_b[31:8]};
        else if (i >= 6'd14) bps_d = {data_byte_i, bps_b[15:8]};
        bps_n = bps_d; ft_eff = ftag_d;
        fin = (i >= 6'd15);
        if (fin && ftag_d == whp_pkg::FmtExt) gm_d = 3'b111;
      end
      whp_pkg::PH_EXT: begin
        if (i >= 6'd8 && i < 6'd24) begin
          for (int k = 0; k < 3; k++) begin
            kk = 2'(k);
            if (data_byte_i != whp_pkg::guid_byte(kk, g)) gm_n[k] = 1'b0;
          end
        end
        gm_d = gm_n;
        fin = (i >= 6'd23);
        consumed = whp_pkg::FmtExtLen;
        // the GUID picks the format tag only once all of it is in
        if (fin) begin
          if (gm_n[0]) ft_eff = whp_pkg::FmtPcm;
          else if (gm_n[2:1] != 2'b00) ft_eff = whp_pkg::FmtFloat;
          ftag_d = ft_eff;
        end
      end
      default: ;
    endcase
    // finish_fmt
    ferr = whp_pkg::ErrNone; fc = 3'd0;
    if (ft_eff == whp_pkg::FmtPcm) begin
      case (bps_n)
        16'd8:  fc = 3'd0;
        16'd16: fc = 3'd1;
        16'd24: fc = 3'd2;
        16'd32: fc = 3'd3;
        default: ferr = whp_pkg::ErrInt;
      endcase
    end else if (ft_eff == whp_pkg::FmtFloat) begin
      if (bps_n == 16'd32) fc = 3'd4;
      else if (bps_n == 16'd64) fc = 3'd5;
      else ferr = whp_pkg::ErrFloat;
    end else ferr = whp_pkg::ErrUnk;
    pad = ({1'b0, len_b} + 33'd1) & ~33'd1;
    if (cmd_i.step) begin
      pos_d = pos_d + 32'd1;
      if (cmd_i.phase == whp_pkg::PH_CHDR && i >= 6'd7) skip_d = ({1'b0, len_d} + 33'd1) & ~33'd1;
      if (cmd_i.phase == whp_pkg::PH_SKIP && skip_b != 33'd0) skip_d = skip_b - 33'd1;
      if (fin && ferr == whp_pkg::ErrNone &&
          !(cmd_i.phase == whp_pkg::PH_FMT && ftag_d == whp_pkg::FmtExt)) begin
        fh_d = fc;
        if (ba_b == 20'd0) ba_d = 20'(bps_n[15:3]) * 20'(ch_b);
        skip_d = pad - {1'b0, consumed};
      end
    end
    stat_o.tag_next  = tag_d;
    stat_o.len_next  = len_d;
    stat_o.ftag_next = ftag_d;
    stat_o.skip_last = (skip_b <= 33'd1);
    stat_o.ba_zero   = (ba_b == 20'd0);
    stat_o.fmt_err   = ferr;
    stat_o.fmt_skip_zero = (pad == {1'b0, consumed});
    stat_o.div_done  = div_done;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      tag_q <= tag_d; len_q <= len_d; rate_q <= rate_d; ftag_q <= ftag_d;
      ch_q <= ch_d; bps_q <= bps_d; skip_q <= skip_d; gm_q <= gm_d;
      fh_q <= fh_d; ba_q <= ba_d; pos_q <= pos_d;
    end
  end

  whp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (len_d),
    .den_i   (ba_b),
    .quot_o  (frames_o),
    .done_o  (div_done)
  );

  assign fmt_o  = fh_q;
  assign chan_o = ch_q;
  assign rate_o = rate_q;
  assign pos_o  = pos_q;

endmodule

@@ design/wav_header_parser_core.sv @@
// An error or truncation word is offered the cycle after its byte, a success word once the
// bit-serial divider has finished after the data header's last byte.
// Throughput: one byte per cycle while parsing; input stalls while dividing or a word is pending.
// Reset (async, active low) leaves the parser idle until a byte flagged first_byte.
module wav_header_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  error_code_o,
  output logic [2:0]  sample_format_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] sample_rate_o,
  output logic [31:0] data_offset_o,
  output logic [31:0] frame_count_o
);

  whp_pkg::cmd_t  cmd;
  whp_pkg::stat_t stat;
  logic [3:0]  err;
  logic        ok;
  logic [2:0]  fmt;
  logic [15:0] ch;
  logic [31:0] rate, pos, frames;

  whp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .first_byte_i, .final_byte_i,
    .out_valid_o, .out_ready_i, .err_o(err), .ok_o(ok), .cmd_o(cmd), .stat_i(stat)
  );

  whp_dp u_dp (
    .clk_i, .rst_ni, .data_byte_i, .cmd_i(cmd), .stat_o(stat),
    .fmt_o(fmt), .chan_o(ch), .rate_o(rate), .pos_o(pos), .frames_o(frames)
  );

  // result fields are zero on error
  assign error_code_o    = err;
  assign sample_format_o = ok ? fmt : 3'd0;
  assign channel_count_o = ok ? ch : 16'd0;
  assign sample_rate_o   = ok ? rate : 32'd0;
  assign data_offset_o   = ok ? pos : 32'd0;
  assign frame_count_o   = ok ? frames : 32'd0;

endmodule
